// ===== hw/rtl/utf8s_pkg.sv =====
// Shared types, constants and decode functions for the UTF-8 sanitizer.
// Used by utf8s_ctrl, utf8s_dpath and utf8_sanitizer; depends on nothing.

package utf8s_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } raw_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
        logic       is_replacement;
    } clean_t;

    // Four-byte scan window: the held prefix plus the newly accepted byte.
    typedef logic [3:0][7:0] win_t;

    typedef enum logic [1:0] {
        SCAN_EMPTY,
        SCAN_HOLD,
        SCAN_PASS,
        SCAN_REPL
    } scan_kind_t;

    typedef struct packed {
        scan_kind_t kind;
        logic [2:0] len;
    } scan_t;

    // Datapath commands from the controller.
    typedef struct packed {
        logic       accept;
        logic       emit;
        logic       emit_repl;
        logic [1:0] repl_idx;
        logic       emit_last;
        logic       shift;
    } dp_cmd_t;

    // Datapath status toward the controller.
    typedef struct packed {
        scan_t      scan;
        logic       rem_last;
        logic [2:0] count;
        logic       out_free;
    } dp_status_t;

    localparam logic [7:0] LEAD2_LO   = 8'hc2;
    localparam logic [7:0] LEAD2_HI   = 8'hdf;
    localparam logic [7:0] LEAD3_LO   = 8'he0;
    localparam logic [7:0] LEAD3_SURR = 8'hed;
    localparam logic [7:0] LEAD4_LO   = 8'hf0;
    localparam logic [7:0] LEAD4_HI   = 8'hf4;
    localparam logic [7:0] CONT_LO    = 8'h80;
    localparam logic [7:0] CONT_HI    = 8'hbf;
    localparam logic [7:0] E0_LO      = 8'ha0;
    localparam logic [7:0] ED_HI      = 8'h9f;
    localparam logic [7:0] F0_LO      = 8'h90;
    localparam logic [7:0] F4_HI      = 8'h8f;
    localparam logic [7:0] REPL_B0    = 8'hef;
    localparam logic [7:0] REPL_B1    = 8'hbf;
    localparam logic [7:0] REPL_B2    = 8'hbd;
    localparam logic [1:0] REPL_LAST  = 2'd2;

    function automatic logic [2:0] seq_len(input logic [7:0] lead);
        logic [2:0] len;
        if (lead <= 8'h7f)
            len = 3'd1;
        else if (lead >= LEAD2_LO && lead <= LEAD2_HI)
            len = 3'd2;
        else if (lead >= LEAD3_LO && lead < LEAD4_LO)
            len = 3'd3;
        else if (lead >= LEAD4_LO && lead <= LEAD4_HI)
            len = 3'd4;
        else
            len = 3'd0;
        return len;
    endfunction

    function automatic logic byte_ok(input logic [7:0] lead, input logic [1:0] pos,
                                     input logic [7:0] b);
        logic ok;
        ok = (b >= CONT_LO && b <= CONT_HI);
        if (pos == 2'd1) begin
            if (lead == LEAD3_LO)
                ok = (b >= E0_LO && b <= CONT_HI);
            else if (lead == LEAD3_SURR)
                ok = (b >= CONT_LO && b <= ED_HI);
            else if (lead == LEAD4_LO)
                ok = (b >= F0_LO && b <= CONT_HI);
            else if (lead == LEAD4_HI)
                ok = (b >= CONT_LO && b <= F4_HI);
        end
        return ok;
    endfunction

    // Decision on the front of the window: pass a whole sequence, replace
    // the lead, hold an incomplete prefix, or nothing to do.
    function automatic scan_t classify(input win_t win, input logic [2:0] n,
                                       input logic fin);
        scan_t      res;
        logic       ok;
        logic [2:0] len;
        len = seq_len(win[0]);
        ok  = (len != 3'd0);
        for (int i = 1; i < 4; i++) begin
            if (3'(i) < n && 3'(i) < len && !byte_ok(win[0], 2'(i), win[i]))
                ok = 1'b0;
        end
        res.len = len;
        if (n == 3'd0)
            res.kind = SCAN_EMPTY;
        else if (ok && n < len)
            res.kind = fin ? SCAN_REPL : SCAN_HOLD;
        else if (ok)
            res.kind = SCAN_PASS;
        else
            res.kind = SCAN_REPL;
        return res;
    endfunction

    function automatic logic [7:0] repl_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = REPL_B0;
            2'd1:    b = REPL_B1;
            default: b = REPL_B2;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/utf8s_dpath.sv =====
// Datapath of the UTF-8 sanitizer: scan window, decode, output register.
// Depends on utf8s_pkg; driven by commands from utf8s_ctrl.

module utf8s_dpath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  utf8s_pkg::raw_t       raw,
    input  utf8s_pkg::dp_cmd_t    cmd,
    output utf8s_pkg::dp_status_t status,
    output logic                  clean_valid,
    input  logic                  clean_ready,
    output utf8s_pkg::clean_t     clean
);
    import utf8s_pkg::*;

    win_t       win_reg,       win_next;
    logic [2:0] count_reg,     count_next;
    logic       final_reg,     final_next;
    clean_t     out_reg,       out_next;
    logic       out_valid_reg, out_valid_next;

    scan_t      scan;
    scan_t      rem_scan;
    win_t       rem_win;
    logic [2:0] rem_n;
    logic [2:0] step;

    assign scan = classify(win_reg, count_reg, final_reg);

    // Look one group ahead so the last byte of a group knows whether it
    // closes the run of results for this request.
    always_comb
    begin
        logic [2:0] j;
        step  = (scan.kind == SCAN_PASS) ? scan.len : 3'd1;
        rem_n = count_reg - step;
        for (int i = 0; i < 4; i++) begin
            j = 3'(i) + step;
            rem_win[i] = j[2] ? 8'h00 : win_reg[j[1:0]];
        end
        rem_scan = classify(rem_win, rem_n, final_reg);
    end

    assign status.scan     = scan;
    assign status.rem_last = (rem_n == 3'd0) || (rem_scan.kind == SCAN_HOLD);
    assign status.count    = count_reg;
    assign status.out_free = !out_valid_reg || clean_ready;

    always_comb
    begin
        win_next       = win_reg;
        count_next     = count_reg;
        final_next     = final_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (cmd.accept) begin
            win_next[count_reg[1:0]] = raw.data_byte;
            count_next               = count_reg + 3'd1;
            final_next               = raw.final_byte;
        end
        if (cmd.shift) begin
            for (int i = 0; i < 3; i++)
                win_next[i] = win_reg[i + 1];
            count_next = count_reg - 3'd1;
        end
        if (cmd.emit) begin
            out_next.out_byte       = cmd.emit_repl ? repl_byte(cmd.repl_idx) : win_reg[0];
            out_next.run_last       = cmd.emit_last;
            out_next.string_done    = cmd.emit_last && final_reg;
            out_next.is_replacement = cmd.emit_repl;
            out_valid_next          = 1'b1;
        end else if (clean_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg     <= 3'd0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        out_reg <= out_next;
    end

    assign clean_valid = out_valid_reg;
    assign clean       = out_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("scan window count out of range");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("emit into an occupied output register");

endmodule

// ===== hw/rtl/utf8s_ctrl.sv =====
// Controller of the UTF-8 sanitizer: sequences accept, scan and emit.
// Depends on utf8s_pkg; drives utf8s_dpath through dp_cmd_t.

module utf8s_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  raw_valid,
    output logic                  raw_ready,
    input  utf8s_pkg::dp_status_t status,
    output utf8s_pkg::dp_cmd_t    cmd
);
    import utf8s_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic       repl_reg,  repl_next;
    logic [1:0] left_reg,  left_next;
    logic [1:0] idx_reg,   idx_next;
    logic       last_reg,  last_next;

    assign raw_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        repl_next     = repl_reg;
        left_next     = left_reg;
        idx_next      = idx_reg;
        last_next     = last_reg;
        cmd           = '0;
        cmd.repl_idx  = idx_reg;
        cmd.emit_repl = repl_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (raw_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                case (status.scan.kind) inside
                    SCAN_PASS, SCAN_REPL:
                    begin
                        repl_next  = (status.scan.kind == SCAN_REPL);
                        left_next  = (status.scan.kind == SCAN_REPL) ? REPL_LAST
                                                                     : 2'(status.scan.len - 3'd1);
                        idx_next   = 2'd0;
                        last_next  = status.rem_last;
                        state_next = ST_EMIT;
                    end
                    default:
                        state_next = ST_IDLE;
                endcase
            end
            ST_EMIT:
            begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = last_reg && (left_reg == 2'd0);
                    // A passed byte leaves the window as it goes out; a
                    // replacement drops the lead after its third byte.
                    cmd.shift     = !repl_reg || (left_reg == 2'd0);
                    left_next     = left_reg - 2'd1;
                    idx_next      = idx_reg + 2'd1;
                    if (left_reg == 2'd0)
                        state_next = last_reg ? ST_IDLE : ST_SCAN;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            repl_reg  <= 1'b0;
            left_reg  <= 2'd0;
            idx_reg   <= 2'd0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            repl_reg  <= repl_next;
            left_reg  <= left_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
        end
    end

    a_idle_settled: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |->
            (status.scan.kind == SCAN_EMPTY || status.scan.kind == SCAN_HOLD))
        else $error("idle with a decidable window");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> status.count != 3'd0)
        else $error("emitting from an empty window");

    a_idle_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> status.count <= 3'd3)
        else $error("no room for the next request");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_last |=> state_reg == ST_IDLE)
        else $error("run ended but controller kept going");

endmodule

// ===== hw/rtl/utf8_sanitizer.sv =====
// Top level of the UTF-8 sanitizer: controller plus datapath.
// Depends on utf8s_pkg, utf8s_ctrl and utf8s_dpath.

// Streams a byte string, one byte per request, and passes well-formed UTF-8
// through unchanged while every invalid or truncated sequence becomes
// EF BF BD with only its lead byte dropped. Each request is accepted, then
// scanned, then emitted one output byte at a time, with one more scan per
// further group it completes. The pace is set by the controller's
// accept-scan-emit sequence and the single output register, which sends one
// byte per cycle while clean_ready is high. Bytes of an incomplete sequence
// are held until it completes or the string ends. The output register lets
// the next request in while a result waits.

module utf8_sanitizer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              raw_valid,
    output logic              raw_ready,
    input  utf8s_pkg::raw_t   raw,
    output logic              clean_valid,
    input  logic              clean_ready,
    output utf8s_pkg::clean_t clean
);
    import utf8s_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    utf8s_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw_valid),
        .raw_ready (raw_ready),
        .status    (status),
        .cmd       (cmd)
    );

    utf8s_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .raw         (raw),
        .cmd         (cmd),
        .status      (status),
        .clean_valid (clean_valid),
        .clean_ready (clean_ready),
        .clean       (clean)
    );

endmodule
